// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the priority set (included by the top file).
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/dept_pkg.sv =====
// Package for the double-ended priority set: operation, status and cell mode codes,
// and the control struct broadcast to the cell chain. No dependencies.
`default_nettype none

package dept_pkg;

    // Operation kinds on the input channel
    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_POP_MIN = 2'd1;
    localparam logic [1:0] KIND_POP_MAX = 2'd2;
    localparam logic [1:0] KIND_REMOVE  = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_DUP    = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_ABSENT = 2'd3;

    // Cell update modes
    localparam logic [1:0] MODE_HOLD   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_CLOSE  = 2'd2;
    localparam logic [1:0] MODE_SHIFT  = 2'd3;

    typedef struct packed {
        logic       cmp_en;
        logic [1:0] mode;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/dept_cell.sv =====
// One cell of the sorted key chain: holds one key and its compare flags.
// Depends on dept_pkg.
`default_nettype none

module dept_cell
    import dept_pkg::*;
#(
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                        aclk,
    input  wire cell_ctrl_t                  ctrl,
    input  wire logic signed [KEY_WIDTH-1:0] cmp_key,
    input  wire logic signed [KEY_WIDTH-1:0] ins_key,
    input  wire logic                        occupied,
    input  wire logic                        left_lt,
    input  wire logic signed [KEY_WIDTH-1:0] left_key,
    input  wire logic signed [KEY_WIDTH-1:0] right_key,
    output logic signed [KEY_WIDTH-1:0]      key_o,
    output logic                             lt_o,
    output logic                             eq_o
);

    logic signed [KEY_WIDTH-1:0] key_reg;
    logic signed [KEY_WIDTH-1:0] key_next;
    logic                        lt_reg;
    logic                        eq_reg;

    always_comb begin
        key_next = key_reg;
        case (ctrl.mode)
            MODE_INSERT: begin
                // first cell at or above the new key takes it; later ones move up
                if (!lt_reg) begin
                    key_next = left_lt ? ins_key : left_key;
                end
            end
            MODE_CLOSE: begin
                if (!lt_reg) begin
                    key_next = right_key;
                end
            end
            MODE_SHIFT: begin
                key_next = right_key;
            end
            default: begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (ctrl.cmp_en) begin
            lt_reg <= occupied && (key_reg < cmp_key);
            eq_reg <= occupied && (key_reg == cmp_key);
        end
    end

    assign key_o = key_reg;
    assign lt_o  = lt_reg;
    assign eq_o  = eq_reg;

endmodule

`default_nettype wire

// ===== rtl/double_ended_priority_set.sv =====
// Double-ended priority set: a bounded ordered set of distinct signed keys.
// Input channel (s_valid/s_ready): s_kind picks insert, remove smallest,
// remove largest or remove given key; s_key is the key for insert and remove.
// Result channel (m_valid/m_ready): one transaction per input with the new
// smallest and largest keys (0 when empty), the count and a status code.
// Keys live in a chain of CAPACITY cells kept in ascending order. Each cell
// compares its key with the incoming key on acceptance, then in the update
// step every cell either holds, takes the new key, or takes its left or right
// neighbor's key, so the chain opens or closes a slot in a single step.
// Sequence: accept, update, then result gather into the output register.
// One transaction is worked on at a time: the next is not accepted until
// the compare / update / gather sequence of the last one is through.
// s_ready is high only while the sequencer is idle and out of reset; a finished
// result waits in the output register and the next transaction may be accepted
// meanwhile. If the receiver stalls, the sequencer holds in its gather step
// until the output register frees up. Reset empties the set and clears m_valid;
// the cell keys need no clearing.
`default_nettype none
`include "assert_macros.svh"

module double_ended_priority_set
    import dept_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic signed [31:0] s_key,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_min_key,
    output logic signed [31:0]      m_max_key,
    output logic [6:0]              m_count,
    output logic [1:0]              m_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [1:0]                  status_reg, status_next;
    logic [1:0]                  kind_reg;
    logic signed [KEY_WIDTH-1:0] key_reg;
    logic                        m_valid_reg, m_valid_next;
    logic [31:0]                 m_min_reg, m_max_reg;
    logic [6:0]                  m_count_reg;
    logic [1:0]                  m_status_reg;

    logic                        accept;
    logic                        load_out;
    logic signed [KEY_WIDTH-1:0] key_in;
    cell_ctrl_t                  ctrl;
    logic [1:0]                  mode;
    logic                        any_eq;
    logic                        full;
    logic                        empty;

    logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]         cell_lt;
    logic [CAPACITY-1:0]         cell_eq;
    logic [CAPACITY-1:0]         occ;
    logic [CAPACITY-1:0]         last;
    logic [KEY_WIDTH-1:0]        min_gather;
    logic [KEY_WIDTH-1:0]        max_gather;

    assign accept = s_valid && s_ready;
    assign key_in = KEY_WIDTH'(s_key);
    assign any_eq = |cell_eq;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);

    assign ctrl = '{cmp_en: accept, mode: mode};

    // Cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                        left_lt;
            logic signed [KEY_WIDTH-1:0] left_key;
            logic signed [KEY_WIDTH-1:0] right_key;

            assign occ[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0) begin : g_head
                assign left_lt  = 1'b1;
                assign left_key = '0;
            end else begin : g_body
                assign left_lt  = cell_lt[gi-1];
                assign left_key = cell_key[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign right_key = cell_key[gi];
                assign last[gi]  = occ[gi];
            end else begin : g_inner
                assign right_key = cell_key[gi+1];
                assign last[gi]  = occ[gi] && !occ[gi+1];
            end

            dept_cell #(
                .KEY_WIDTH(KEY_WIDTH)
            ) u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .cmp_key  (key_in),
                .ins_key  (key_reg),
                .occupied (occ[gi]),
                .left_lt  (left_lt),
                .left_key (left_key),
                .right_key(right_key),
                .key_o    (cell_key[gi]),
                .lt_o     (cell_lt[gi]),
                .eq_o     (cell_eq[gi])
            );
        end
    endgenerate

    // Decide the operation outcome from the registered compare flags
    always_comb begin
        mode        = MODE_HOLD;
        count_next  = count_reg;
        status_next = status_reg;
        if (state_reg == ST_UPD) begin
            status_next = STAT_DONE;
            case (kind_reg)
                KIND_INSERT: begin
                    if (any_eq) begin
                        status_next = STAT_DUP;
                    end else if (full) begin
                        status_next = STAT_FULL;
                    end else begin
                        mode       = MODE_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_POP_MIN: begin
                    if (empty) begin
                        status_next = STAT_ABSENT;
                    end else begin
                        mode       = MODE_SHIFT;
                        count_next = count_reg - 1'b1;
                    end
                end
                KIND_POP_MAX: begin
                    // drop the top entry by shortening the count
                    if (empty) begin
                        status_next = STAT_ABSENT;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end
                KIND_REMOVE: begin
                    if (any_eq) begin
                        mode       = MODE_CLOSE;
                        count_next = count_reg - 1'b1;
                    end else begin
                        status_next = STAT_ABSENT;
                    end
                end
                default: begin
                    status_next = STAT_ABSENT;
                end
            endcase
        end
    end

    // Gather smallest and largest keys from the chain
    always_comb begin
        min_gather = empty ? '0 : cell_key[0];
        max_gather = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            max_gather = max_gather | (cell_key[i] & {KEY_WIDTH{last[i]}});
        end
    end

    assign load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Sequencer and output handshake
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (load_out) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (accept) begin
            kind_reg <= s_kind;
            key_reg  <= key_in;
        end
        if (load_out) begin
            m_min_reg    <= 32'(min_gather);
            m_max_reg    <= 32'(max_gather);
            m_count_reg  <= 7'(count_reg);
            m_status_reg <= status_reg;
        end
    end

    assign s_ready   = aresetn && (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_min_key = m_min_reg;
    assign m_max_key = m_max_reg;
    assign m_count   = m_count_reg;
    assign m_status  = m_status_reg;

    // Checks
    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `ASSERT_IMPLIES(a_count_step, aclk, aresetn, (state_reg == ST_OUT) && ($past(state_reg) == ST_UPD), (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1), "count moved by more than one")
    `ASSERT_IMPLIES(a_full_status, aclk, aresetn, (state_reg == ST_OUT) && (status_reg == STAT_FULL), full, "full status with free slots")
    `ASSERT_IMPLIES(a_result_source, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == ST_OUT, "result raised outside gather step")

endmodule

`default_nettype wire
